// File: rtl/bsl_pkg.sv
// Package for the brightest spot locator: payload types, register indexes, reset values.
package bsl_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned SPOT_W   = 10;
  localparam int unsigned FWIDTH_W = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd1;

  localparam logic [LEVEL_W-1:0]  RESET_THRESHOLD   = 8'd235;
  localparam logic [FWIDTH_W-1:0] RESET_FRAME_WIDTH = 11'd640;

  typedef struct packed {
    logic [LEVEL_W-1:0] intensity;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic [SPOT_W-1:0]  spot_x;
    logic [SPOT_W-1:0]  spot_y;
    logic [LEVEL_W-1:0] peak;
    logic               found;
  } result_t;

endpackage

// File: rtl/brightest_spot_locator_top.sv
// Brightest spot locator: tracks the brightest above-threshold pixel of each frame.
// A frame's result is registered in res when its last pixel is taken, or in skid if stalled.
// Throughput: one pixel per cycle while not stalled; compare-and-update is one registered pass.
// A two-entry result buffer (output register plus skid) keeps pixels flowing while a
// result waits; pix_stall rises only when both entries hold results.
// Reset (synchronous, active high) clears frame state and results; threshold 235, width 640.
module brightest_spot_locator_top
  import bsl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pixel_t               pix,
  output logic                 res_valid,
  input  logic                 res_stall,
  output result_t              res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FWIDTH_W-1:0]  cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW = (CW + 1 > FWIDTH_W) ? CW + 1 : FWIDTH_W;

  logic [LEVEL_W-1:0]  threshold;
  logic [FWIDTH_W-1:0] frame_width;

  logic [LEVEL_W-1:0] best_level, best_level_next;
  logic [CW-1:0]      best_col, best_col_next;
  logic [RW-1:0]      best_row, best_row_next;
  logic [CW-1:0]      col_count;
  logic [RW-1:0]      row_count;

  result_t res_next;
  result_t skid;
  logic    skid_valid;

  logic              pix_take;
  logic              qualify;
  logic [LW-1:0]     fw_ext;
  logic [LW-1:0]     eff_width;
  logic [LW-1:0]     col_inc;
  logic [SPOT_W+CW-1:0] col_ext;
  logic [SPOT_W+RW-1:0] row_ext;
  logic              res_free;

  assign cfg_ready = 1'b1;
  assign pix_stall = skid_valid;
  assign pix_take  = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= RESET_THRESHOLD;
      frame_width <= RESET_FRAME_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:   threshold   <= cfg_data[LEVEL_W-1:0];
        REG_FRAME_WIDTH: frame_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = LW'(frame_width);
    if (fw_ext == '0 || fw_ext > LW'(MAX_WIDTH)) begin
      eff_width = LW'(MAX_WIDTH);
    end else begin
      eff_width = fw_ext;
    end
    col_inc = LW'(col_count) + LW'(1);

    qualify = (pix.intensity > threshold) && (pix.intensity > best_level);
    if (qualify) begin
      best_level_next = pix.intensity;
      best_col_next   = col_count;
      best_row_next   = row_count;
    end else begin
      best_level_next = best_level;
      best_col_next   = best_col;
      best_row_next   = best_row;
    end

    // best position stays zero until a pixel qualifies, so no masking needed
    col_ext = {{SPOT_W{1'b0}}, best_col_next};
    row_ext = {{SPOT_W{1'b0}}, best_row_next};
    res_next.spot_x = col_ext[SPOT_W-1:0];
    res_next.spot_y = row_ext[SPOT_W-1:0];
    res_next.peak   = best_level_next;
    res_next.found  = (best_level_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_level <= '0;
      best_col   <= '0;
      best_row   <= '0;
      col_count  <= '0;
      row_count  <= '0;
    end else if (pix_take) begin
      if (pix.frame_end) begin
        best_level <= '0;
        best_col   <= '0;
        best_row   <= '0;
        col_count  <= '0;
        row_count  <= '0;
      end else begin
        best_level <= best_level_next;
        best_col   <= best_col_next;
        best_row   <= best_row_next;
        if (col_inc >= eff_width) begin
          col_count <= '0;
          if (row_count < RW'(MAX_HEIGHT - 1)) begin
            row_count <= row_count + RW'(1);
          end
        end else begin
          col_count <= col_inc[CW-1:0];
        end
      end
    end
  end

  assign res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_free) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= pix_take && pix.frame_end;
      end
    end else if (pix_take && pix.frame_end) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free) begin
      if (skid_valid) begin
        res <= skid;
      end else if (pix_take && pix.frame_end) begin
        res <= res_next;
      end
    end else if (pix_take && pix.frame_end) begin
      skid <= res_next;
    end
  end

endmodule

// File: tb/sv/spot_tracker_pkg.sv
// Scoreboard class: predicts brightest-spot results per frame and checks them.
`timescale 1ns / 1ps

package spot_tracker_pkg;
  import bsl_pkg::*;

  localparam int unsigned TRACK_MAX_WIDTH  = 1024;
  localparam int unsigned TRACK_MAX_HEIGHT = 1024;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  class spot_tracker;
    logic [LEVEL_W-1:0]  threshold;
    logic [FWIDTH_W-1:0] frame_width;
    logic [LEVEL_W-1:0]  best_level;
    logic [SPOT_W-1:0]   best_col;
    logic [SPOT_W-1:0]   best_row;
    int unsigned         col_pos;
    int unsigned         row_pos;
    result_t             pending_spots[$];
    int unsigned         mismatches;
    int unsigned         pixels_seen;
    int unsigned         frames_checked;
    int unsigned         spots_found;

    function new();
      threshold      = RESET_THRESHOLD;
      frame_width    = RESET_FRAME_WIDTH;
      mismatches     = 0;
      pixels_seen    = 0;
      frames_checked = 0;
      spots_found    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      best_level = '0;
      best_col   = '0;
      best_row   = '0;
      col_pos    = 0;
      row_pos    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FWIDTH_W-1:0] data);
      if (idx == REG_THRESHOLD) begin
        threshold = data[LEVEL_W-1:0];
      end else begin
        frame_width = data;
      end
    endfunction

    function int unsigned pending();
      return pending_spots.size();
    endfunction

    // one accepted pixel transaction
    function void take_pixel(pixel_t p);
      int unsigned span;
      result_t     spot;
      span = (frame_width == 0 || frame_width > TRACK_MAX_WIDTH) ?
             TRACK_MAX_WIDTH : int'(frame_width);
      pixels_seen++;
      if (p.intensity > threshold && p.intensity > best_level) begin
        best_level = p.intensity;
        best_col   = SPOT_W'(col_pos);
        best_row   = SPOT_W'(row_pos);
      end
      if (p.frame_end) begin
        spot.found  = (best_level != 0);
        spot.spot_x = spot.found ? best_col : '0;
        spot.spot_y = spot.found ? best_row : '0;
        spot.peak   = spot.found ? best_level : '0;
        pending_spots.push_back(spot);
        clear_frame();
        return;
      end
      if (col_pos + 1 >= span) begin
        col_pos = 0;
        if (row_pos < TRACK_MAX_HEIGHT - 1) row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    // one accepted result transaction
    function void check_spot(result_t got);
      result_t want;
      if (pending_spots.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result: x=%0d y=%0d peak=%0d found=%0d",
                   got.spot_x, got.spot_y, got.peak, got.found);
        return;
      end
      want = pending_spots.pop_front();
      frames_checked++;
      if (want.found) spots_found++;
      if (got.spot_x !== want.spot_x || got.spot_y !== want.spot_y ||
          got.peak !== want.peak || got.found !== want.found) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
          $display("mismatch frame %0d: exp x=%0d y=%0d peak=%0d found=%0d",
                   frames_checked, want.spot_x, want.spot_y, want.peak, want.found);
          $display("  got x=%0d y=%0d peak=%0d found=%0d",
                   got.spot_x, got.spot_y, got.peak, got.found);
        end
      end
    endfunction
  endclass

endpackage

// File: tb/sv/brightest_spot_locator_top_test.sv
// Testbench top: drives pixel frames and register writes, checks each frame's spot.
`timescale 1ns / 1ps

module brightest_spot_locator_top_test;
  import bsl_pkg::*;
  import spot_tracker_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pixel_t               pix = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  result_t              res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FWIDTH_W-1:0]  cfg_data = '0;

  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          cycles = 0;
  int unsigned          settings_used = 0;
  logic [LEVEL_W-1:0]   cur_thr = RESET_THRESHOLD;

  spot_tracker sb = new();

  brightest_spot_locator_top dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) sb.take_pixel(pix);
      if (res_valid && !res_stall) sb.check_spot(res);
    end
  end

  task automatic send_pixel(logic [LEVEL_W-1:0] level, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= '{intensity: level, frame_end: last};
    do @(posedge clk); while (pix_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FWIDTH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
    if (idx == REG_THRESHOLD) cur_thr = data[LEVEL_W-1:0];
  endtask

  // drain outstanding results, then allow the pipeline to go quiet
  task automatic settle();
    pix_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level(logic [LEVEL_W-1:0] thr);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return thr;
      3:       return (thr == '1) ? thr : thr + 1'b1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // hot < 0: random content; otherwise one 255 pixel at index hot, rest below 255
  task automatic send_frame(int unsigned len, int hot);
    logic [LEVEL_W-1:0] level;
    for (int unsigned i = 0; i < len; i++) begin
      if (hot < 0) level = pick_level(cur_thr);
      else if (int'(i) == hot) level = '1;
      else level = LEVEL_W'($urandom_range(0, 254));
      send_pixel(level, i == len - 1);
    end
  endtask

  initial begin
    int unsigned         sent;
    int unsigned         len;
    logic [LEVEL_W-1:0]  thr;
    logic [FWIDTH_W-1:0] span;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then threshold and width extremes
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd235, 1'b1);
    send_pixel(8'd236, 1'b0);
    send_pixel(8'd236, 1'b1);
    send_pixel(8'd0, 1'b1);
    settle();
    write_reg(REG_THRESHOLD, 11'd0);
    write_reg(REG_FRAME_WIDTH, 11'd3);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd4, 1'b1);
    settle();
    write_reg(REG_THRESHOLD, 11'h7FF);
    write_reg(REG_FRAME_WIDTH, 11'd1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    settle();
    write_reg(REG_THRESHOLD, 11'd100);
    write_reg(REG_FRAME_WIDTH, 11'd0);
    send_pixel(8'd101, 1'b0);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd101, 1'b1);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd2047);
    send_pixel(8'd200, 1'b1);
    settle();
    settings_used += 4;

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(0, 5))
          0:       thr = '0;
          1:       thr = '1;
          2:       thr = RESET_THRESHOLD;
          default: thr = LEVEL_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
          0:       span = '0;
          1:       span = FWIDTH_W'($urandom_range(1025, 2047));
          2:       span = 11'd1;
          default: span = FWIDTH_W'($urandom_range(2, 8));
        endcase
        write_reg(REG_THRESHOLD, {3'($urandom), thr});
        write_reg(REG_FRAME_WIDTH, span);
        settings_used++;
        sent = 0;
        while (sent < 67) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
          send_frame(len, -1);
          sent += len;
        end
        settle();
      end
    end

    $display("Covered %0d pixels in %0d frames (%0d with a spot) over %0d register settings.",
             sb.pixels_seen, sb.frames_checked, sb.spots_found, settings_used);
    $display("Idle mixes: sender-heavy, receiver-heavy, none; %0d mismatches, %0d left over.",
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
